// ===== hdl/lease_grant_table_macros.svh =====
// Assertion helpers for the lease grant table.
// Both forms sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef LEASE_GRANT_TABLE_MACROS_SVH
`define LEASE_GRANT_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold in the same cycle.
`define LGT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define LGT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LGT_ASSERT(lbl, prop, msg)
`define LGT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/lgt_pkg.sv =====
`default_nettype none

package lgt_pkg;

    // Field widths
    localparam int KEY_W    = 64;
    localparam int TIME_W   = 48;
    localparam int CLIENT_W = 8;
    localparam int PERIOD_W = 32;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 2;

    // Table defaults
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int CLIENT_COUNT      = 256;

    // Register map and reset value
    localparam logic [ADDR_W-1:0]   REG_LEASE_PERIOD   = 2'd0;
    localparam logic [PERIOD_W-1:0] LEASE_PERIOD_RESET = 32'd1000;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DENIED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED  = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Request traveling down the chain, with the result filled in by the
    // cell that resolves it
    typedef struct packed {
        logic [KEY_W-1:0]    key_high;
        logic [KEY_W-1:0]    key_low;
        logic [CLIENT_W-1:0] req;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   fresh;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   due;
        logic [CLIENT_W-1:0] holder;
    } lgt_token_t;

    // Requester id modulo the client count; the count is a power of two,
    // so this reduces to a mask
    function automatic logic [CLIENT_W-1:0] client_reduce(input logic [CLIENT_W-1:0] id);
        logic [31:0] wide;
        wide = {{(32 - CLIENT_W){1'b0}}, id};
        return CLIENT_W'(wide % 32'(CLIENT_COUNT));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lgt_cell.sv =====
`default_nettype none

module lgt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  lgt_pkg::lgt_token_t in_tok,
    output logic               out_valid,
    output lgt_pkg::lgt_token_t out_tok
);
    import lgt_pkg::*;
    `include "lease_grant_table_macros.svh"

    logic                entry_valid_reg;
    logic [KEY_W-1:0]    key_high_reg;
    logic [KEY_W-1:0]    key_low_reg;
    logic [TIME_W-1:0]   due_reg;
    logic [CLIENT_W-1:0] holder_reg;
    logic                out_valid_reg;
    lgt_token_t          out_tok_reg;
    lgt_token_t          out_tok_next;

    logic key_match;
    logic hit;
    logic claim;
    logic expired;
    logic renew;

    // Lookup against this entry; valid entries form a prefix, so the first
    // empty cell reached is the lowest free slot
    always_comb
    begin
        key_match = entry_valid_reg && (key_high_reg == in_tok.key_high)
                    && (key_low_reg == in_tok.key_low);
        hit       = in_valid && !in_tok.done && key_match;
        claim     = in_valid && !in_tok.done && !entry_valid_reg;
        expired   = (in_tok.now >= due_reg);
        renew     = claim || (hit && expired);
    end

    // Result for the request leaving this cell
    always_comb
    begin
        out_tok_next = in_tok;
        if (renew)
        begin
            out_tok_next.done   = 1'b1;
            out_tok_next.status = ST_GRANTED;
            out_tok_next.due    = in_tok.fresh;
            out_tok_next.holder = in_tok.req;
        end
        else if (hit)
        begin
            out_tok_next.done   = 1'b1;
            out_tok_next.due    = due_reg;
            out_tok_next.holder = holder_reg;
            out_tok_next.status = (holder_reg == in_tok.req) ? ST_GRANTED : ST_DENIED;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (claim)
            begin
                entry_valid_reg <= 1'b1;
            end
            out_valid_reg <= in_valid;
        end
    end

    // Entry contents and forwarded request
    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            key_high_reg <= in_tok.key_high;
            key_low_reg  <= in_tok.key_low;
        end
        if (renew)
        begin
            due_reg    <= in_tok.fresh;
            holder_reg <= in_tok.req;
        end
        out_tok_reg <= out_tok_next;
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

    // Checks
    `LGT_ASSERT_NEXT(a_entry_sticks, entry_valid_reg, entry_valid_reg, "entry lost its valid bit")
    `LGT_ASSERT_NEXT(a_token_moves, in_valid, out_valid, "request dropped in cell")
    `LGT_ASSERT_NEXT(a_done_kept, in_valid && in_tok.done,
        out_tok.done && (out_tok.status == $past(in_tok.status)), "resolved result altered")
    `LGT_ASSERT(a_claim_empty, !(claim && hit), "claim and hit in one cell")

endmodule

`default_nettype wire

// ===== hdl/lease_grant_table.sv =====
// Lease grant table: grants time-limited exclusive leases on 128-bit object
// ids. One request is handled at a time. An accepted request walks a chain of
// TABLE_ENTRIES cells, one cell per cycle, each cell holding one lease entry;
// the request is registered at the chain head, then in each cell in turn,
// and the result is captured in an output register; in_stall stays high
// from acceptance until that result is taken. The lease period register
// sits at byte address 0 of the APB port and resets to 1000 ticks; write
// it only while no request is in flight.
`default_nettype none

module lease_grant_table #(
    parameter int TABLE_ENTRIES = lgt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lgt_pkg::ADDR_W-1:0]    paddr,
    input  logic [lgt_pkg::DATA_W-1:0]    pwdata,
    output logic [lgt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,

    // Request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lgt_pkg::KEY_W-1:0]     object_id_high,
    input  logic [lgt_pkg::KEY_W-1:0]     object_id_low,
    input  logic [lgt_pkg::CLIENT_W-1:0]  requester_id,
    input  logic [lgt_pkg::TIME_W-1:0]    current_time,

    // Result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lgt_pkg::STATUS_W-1:0]  status,
    output logic [lgt_pkg::TIME_W-1:0]    due_time,
    output logic [lgt_pkg::CLIENT_W-1:0]  holder_id
);
    import lgt_pkg::*;
    `include "lease_grant_table_macros.svh"

    logic [PERIOD_W-1:0] lease_period_reg;
    logic                busy_reg;
    logic                head_valid_reg;
    lgt_token_t          head_tok_reg;
    lgt_token_t          head_tok_next;
    logic                out_valid_reg;
    lgt_token_t          out_tok_reg;

    logic [TABLE_ENTRIES:0] tok_valid;
    lgt_token_t             tok [0:TABLE_ENTRIES];

    logic              in_accept;
    logic              out_accept;
    logic              cfg_write;
    logic [TIME_W:0]   due_sum;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign cfg_write  = psel && penable && pwrite && pready && (paddr == REG_LEASE_PERIOD);

    // APB register access
    assign pready = 1'b1;
    assign prdata = (paddr == REG_LEASE_PERIOD) ? lease_period_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lease_period_reg <= LEASE_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            lease_period_reg <= pwdata;
        end
    end

    // New request: saturated due time and an unresolved result
    always_comb
    begin
        due_sum                = {1'b0, current_time} + (TIME_W + 1)'(lease_period_reg);
        head_tok_next.key_high = object_id_high;
        head_tok_next.key_low  = object_id_low;
        head_tok_next.req      = client_reduce(requester_id);
        head_tok_next.now      = current_time;
        head_tok_next.fresh    = due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];
        head_tok_next.done     = 1'b0;
        head_tok_next.status   = ST_FULL;
        head_tok_next.due      = '0;
        head_tok_next.holder   = '0;
    end

    // Transaction control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            head_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_valid_reg <= in_accept;
            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                busy_reg <= 1'b0;
            end
            if (tok_valid[TABLE_ENTRIES])
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers at both ends of the chain
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            head_tok_reg <= head_tok_next;
        end
        if (tok_valid[TABLE_ENTRIES])
        begin
            out_tok_reg <= tok[TABLE_ENTRIES];
        end
    end

    assign tok_valid[0] = head_valid_reg;
    assign tok[0]       = head_tok_reg;

    // Chain of entry cells
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        lgt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (tok_valid[i]),
            .in_tok    (tok[i]),
            .out_valid (tok_valid[i+1]),
            .out_tok   (tok[i+1])
        );
    end

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign status    = out_tok_reg.status;
    assign due_time  = out_tok_reg.due;
    assign holder_id = out_tok_reg.holder;

    // Checks
    `LGT_ASSERT(a_single_flight, $onehot0({tok_valid, out_valid_reg}), "more than one request in flight")
    `LGT_ASSERT(a_result_blocks, !out_valid_reg || in_stall, "request taken while result pending")
    `LGT_ASSERT(a_idle_empty, busy_reg || (tok_valid == '0), "chain active while idle")
    `LGT_ASSERT(a_status_code, !out_valid_reg || (status != ST_UNUSED), "undefined status code")

endmodule

`default_nettype wire
